// File: rtl/baro_pressure_compensation_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the barometric pressure compensation block
// Concurrent checks on clk; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BARO_PRESSURE_COMPENSATION_DEFINES_SVH
`define BARO_PRESSURE_COMPENSATION_DEFINES_SVH
`ifndef SYNTHESIS
// check that is switched off while rst is high
`define BPC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("bpc check failed");
// check that also holds during reset
`define BPC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("bpc check failed");
`else
`define BPC_ASSERT(lbl, prop)
`define BPC_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// File: rtl/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types and constants of the pressure compensation pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bpc_pkg;

  // divider chain: one quotient bit per cell
  localparam int DIV_STEPS  = 64;
  localparam int REM_W      = 31;
  // 13 stages before the chain, 6 after it
  localparam int PIPE_DEPTH = 19 + DIV_STEPS;

  localparam logic signed [31:0] TFINE_OFFSET = 32'sd128000;
  localparam logic [20:0]        P_FULL_SCALE = 21'd1048576;
  localparam logic [63:0]        DIV_SCALE    = 64'd3125;
  localparam logic [63:0]        Y1_BIAS      = 64'h0000_8000_0000_0000;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_DEN = 2'd1;
  localparam logic [1:0] ST_CLAMPED  = 2'd2;

  // register index
  typedef enum logic [1:0] {
    REG_TEMP_CALIB    = 2'd0,
    REG_PRESS_CALIB_A = 2'd1,
    REG_PRESS_CALIB_B = 2'd2,
    REG_PRESS_CALIB_C = 2'd3
  } bpc_reg_t;

  // per-item data that rides along the divider chain
  typedef struct packed {
    logic [31:0] tfine;
    logic        zero;
    logic        negq;
  } bpc_side_t;

  // state of one divider cell
  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [63:0]      dq;
    logic [REM_W-1:0] mb;
    bpc_side_t        side;
  } bpc_div_t;

endpackage

// File: rtl/bpc_mul64.sv
// ----------------------------------------------------------------------------
// bpc_mul64
// Two-stage 64x64 multiplier, low 64 bits of the product (wraps mod 2^64).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpc_mul64 (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] p
);

  logic [63:0] ll;
  logic [31:0] lh;
  logic [31:0] hl;

  // stage 1: 32x32 partial products, cross terms only need their low half
  always_ff @(posedge clk) begin
    if (en) begin
      ll <= 64'(a[31:0]) * 64'(b[31:0]);
      lh <= a[31:0] * b[63:32];
      hl <= a[63:32] * b[31:0];
    end
  end

  // stage 2: combine
  always_ff @(posedge clk) begin
    if (en) begin
      p <= ll + {lh + hl, 32'd0};
    end
  end

endmodule

// File: rtl/bpc_div_cell.sv
// ----------------------------------------------------------------------------
// bpc_div_cell
// One restoring division step: shifts in a dividend bit, emits a quotient bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpc_div_cell (
  input  logic            clk,
  input  logic            en,
  input  bpc_pkg::bpc_div_t din,
  output bpc_pkg::bpc_div_t dout
);
  import bpc_pkg::*;

  logic [REM_W:0] trial;
  logic [REM_W:0] diff;
  logic           ge;

  // partial remainder with the next dividend bit
  always_comb begin
    trial = {din.rem, din.dq[63]};
    diff  = trial - {1'b0, din.mb};
    ge    = (trial >= {1'b0, din.mb});
  end

  // dividend bits shift out the top, quotient bits shift in at the bottom
  always_ff @(posedge clk) begin
    if (en) begin
      dout.rem  <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
      dout.dq   <= {din.dq[62:0], ge};
      dout.mb   <= din.mb;
      dout.side <= din.side;
    end
  end

endmodule

// File: rtl/baro_pressure_compensation.sv
// ----------------------------------------------------------------------------
// baro_pressure_compensation
// Fine temperature and 64-bit integer compensated pressure (Q24.8 pascal).
// ----------------------------------------------------------------------------
//   channel   | dir | content
//   s_axis    | in  | tdata: raw_temperature, raw_pressure
//   m_axis    | out | tdata: pressure_q24_8, fine_temperature, status
//   apb       | in  | four calibration registers at 8*i, 64-bit data
//
// One item per cycle unless the output stalls; each item passes through
// 19 arithmetic stages plus a row of 64 divider cells, one quotient bit each.
// The whole pipeline advances together; it holds while the output item is
// not taken, and the input is ready whenever the output is empty or taken.
// Synchronous reset empties the pipeline and clears the calibration.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "baro_pressure_compensation_defines.svh"

module baro_pressure_compensation (
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // raw_temperature[19:0], raw_pressure[39:20]
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // pressure_q24_8[31:0], fine_temperature[63:32],
                                 // status[65:64], zero fill
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import bpc_pkg::*;

  // --------------------------------------------------------------------------
  // configuration registers
  logic [47:0] temp_calib;
  logic [63:0] press_calib_a;
  logic [63:0] press_calib_b;
  logic [15:0] press_calib_c;
  bpc_reg_t    reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = bpc_reg_t'(paddr[4:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_calib    <= '0;
      press_calib_a <= '0;
      press_calib_b <= '0;
      press_calib_c <= '0;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        REG_TEMP_CALIB:    temp_calib    <= pwdata[47:0];
        REG_PRESS_CALIB_A: press_calib_a <= pwdata;
        REG_PRESS_CALIB_B: press_calib_b <= pwdata;
        REG_PRESS_CALIB_C: press_calib_c <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_TEMP_CALIB:    prdata = {16'd0, temp_calib};
      REG_PRESS_CALIB_A: prdata = press_calib_a;
      REG_PRESS_CALIB_B: prdata = press_calib_b;
      REG_PRESS_CALIB_C: prdata = {48'd0, press_calib_c};
      default:           prdata = '0;
    endcase
  end

  // calibration words
  logic        [15:0] t1;
  logic signed [15:0] t2, t3;
  logic        [15:0] p1;
  logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;

  assign t1 = temp_calib[15:0];
  assign t2 = temp_calib[31:16];
  assign t3 = temp_calib[47:32];
  assign p1 = press_calib_a[15:0];
  assign p2 = press_calib_a[31:16];
  assign p3 = press_calib_a[47:32];
  assign p4 = press_calib_a[63:48];
  assign p5 = press_calib_b[15:0];
  assign p6 = press_calib_b[31:16];
  assign p7 = press_calib_b[47:32];
  assign p8 = press_calib_b[63:48];
  assign p9 = press_calib_c;

  // --------------------------------------------------------------------------
  // pipeline control: all stages advance together
  logic                  en;
  logic [PIPE_DEPTH-1:0] vld;

  assign en       = !vld[PIPE_DEPTH-1] || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[PIPE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_DEPTH-2:0], s_tvalid};
    end
  end

  // --------------------------------------------------------------------------
  // temperature stages (exact arithmetic)
  logic signed [17:0] da1;
  logic signed [16:0] db1;
  logic        [19:0] ap1, ap2, ap3, ap4, ap5, ap6, ap7, ap8, ap9;
  logic signed [33:0] pa2, sq2;
  logic signed [22:0] ta3;
  logic signed [37:0] pt3;
  logic signed [31:0] tf4, tf5, tf6, tf7, tf8, tf9, tf10, tf11, tf12;

  always_ff @(posedge clk) begin
    if (en) begin
      da1 <= 18'(s_tdata[19:3]) - 18'({t1, 1'b0});
      db1 <= 17'(s_tdata[19:4]) - 17'(t1);
      ap1 <= s_tdata[39:20];
      pa2 <= 34'(da1) * 34'(t2);
      sq2 <= 34'(db1) * 34'(db1);
      ap2 <= ap1;
      ta3 <= pa2[33:11];
      pt3 <= 38'($signed(sq2[33:12])) * 38'(t3);
      ap3 <= ap2;
      tf4 <= 32'(ta3) + 32'($signed(pt3[37:14]));
      ap4 <= ap3;
    end
  end

  // --------------------------------------------------------------------------
  // pressure polynomial stages
  logic signed [24:0] x15;
  logic signed [49:0] sqx_w;
  logic signed [40:0] m5_w, m2_w;
  logic        [63:0] sqx6, m5_6, m2_6, m5_7, m2_7, m5_8, m2_8;
  logic        [63:0] a6, a3;
  logic        [63:0] x2_9, y1b9, y1b10, num10;
  logic        [20:0] pd9;

  assign sqx_w = 50'(x15) * 50'(x15);
  assign m5_w  = 41'(x15) * 41'(p5);
  assign m2_w  = 41'(x15) * 41'(p2);
  assign pd9   = P_FULL_SCALE - 21'(ap9);

  always_ff @(posedge clk) begin
    if (en) begin
      x15   <= 25'(tf4 - TFINE_OFFSET);
      tf5   <= tf4;
      ap5   <= ap4;
      sqx6  <= 64'(sqx_w);
      m5_6  <= 64'(m5_w);
      m2_6  <= 64'(m2_w);
      tf6   <= tf5;
      ap6   <= ap5;
      m5_7  <= m5_6;
      m2_7  <= m2_6;
      tf7   <= tf6;
      ap7   <= ap6;
      m5_8  <= m5_7;
      m2_8  <= m2_7;
      tf8   <= tf7;
      ap8   <= ap7;
      x2_9  <= a6 + (m5_8 << 17) + (64'(p4) << 35);
      y1b9  <= Y1_BIAS + 64'($signed(a3) >>> 8) + (m2_8 << 12);
      tf9   <= tf8;
      ap9   <= ap8;
      num10 <= (64'(pd9) << 31) - x2_9;
      y1b10 <= y1b9;
      tf10  <= tf9;
      tf11  <= tf10;
      tf12  <= tf11;
    end
  end

  bpc_mul64 u_mul_p6 (.clk(clk), .en(en), .a(sqx6), .b(64'(p6)), .p(a6));
  bpc_mul64 u_mul_p3 (.clk(clk), .en(en), .a(sqx6), .b(64'(p3)), .p(a3));

  // denominator and scaled numerator
  logic [63:0] y1p, dp;

  bpc_mul64 u_mul_p1  (.clk(clk), .en(en), .a(y1b10), .b({48'd0, p1}), .p(y1p));
  bpc_mul64 u_mul_div (.clk(clk), .en(en), .a(num10), .b(DIV_SCALE), .p(dp));

  // --------------------------------------------------------------------------
  // divider: signs split off, magnitudes into the cell row
  logic [REM_W-1:0] y1;
  bpc_div_t         chain [0:DIV_STEPS];

  assign y1 = y1p[63:33];

  always_ff @(posedge clk) begin
    if (en) begin
      chain[0].rem        <= '0;
      chain[0].dq         <= dp[63] ? (64'd0 - dp) : dp;
      chain[0].mb         <= y1[REM_W-1] ? (REM_W'(0) - y1) : y1;
      chain[0].side.tfine <= tf12;
      chain[0].side.zero  <= (y1 == '0);
      chain[0].side.negq  <= dp[63] ^ y1[REM_W-1];
    end
  end

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    bpc_div_cell u_cell (
      .clk (clk),
      .en  (en),
      .din (chain[i]),
      .dout(chain[i+1])
    );
  end

  // --------------------------------------------------------------------------
  // correction terms
  logic [63:0] q14, q15, q16, q17, q18;
  logic [63:0] ps14, ps15, ps16;
  logic [31:0] tf14, tf15, tf16, tf17, tf18;
  logic        z14, z15, z16, z17, z18;
  logic [63:0] pr9, pr8, pr8_17, pr8_18, c9p;

  assign ps14 = 64'($signed(q14) >>> 13);

  always_ff @(posedge clk) begin
    if (en) begin
      q14    <= chain[DIV_STEPS].side.negq ? (64'd0 - chain[DIV_STEPS].dq)
                                           : chain[DIV_STEPS].dq;
      tf14   <= chain[DIV_STEPS].side.tfine;
      z14    <= chain[DIV_STEPS].side.zero;
      q15    <= q14;
      q16    <= q15;
      q17    <= q16;
      q18    <= q17;
      ps15   <= ps14;
      ps16   <= ps15;
      tf15   <= tf14;
      tf16   <= tf15;
      tf17   <= tf16;
      tf18   <= tf17;
      z15    <= z14;
      z16    <= z15;
      z17    <= z16;
      z18    <= z17;
      pr8_17 <= pr8;
      pr8_18 <= pr8_17;
    end
  end

  bpc_mul64 u_mul_p9 (.clk(clk), .en(en), .a(ps14), .b(64'(p9)), .p(pr9));
  bpc_mul64 u_mul_p8 (.clk(clk), .en(en), .a(q14), .b(64'(p8)), .p(pr8));
  bpc_mul64 u_mul_ps (.clk(clk), .en(en), .a(pr9), .b(ps16), .p(c9p));

  // --------------------------------------------------------------------------
  // final sum, clamp and output register
  logic [63:0] psum, pfin;
  logic [31:0] press_next;
  logic [1:0]  status_next;
  logic [31:0] out_pressure;
  logic [31:0] out_tfine;
  logic [1:0]  out_status;

  always_comb begin
    psum = q18 + 64'($signed(c9p) >>> 25) + 64'($signed(pr8_18) >>> 19);
    pfin = 64'($signed(psum) >>> 8) + (64'(p7) << 4);
    if (z18) begin
      press_next  = '0;
      status_next = ST_ZERO_DEN;
    end else if (pfin[63]) begin
      press_next  = '0;
      status_next = ST_CLAMPED;
    end else if (pfin[63:32] != '0) begin
      press_next  = '1;
      status_next = ST_CLAMPED;
    end else begin
      press_next  = pfin[31:0];
      status_next = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_pressure <= press_next;
      out_tfine    <= tf18;
      out_status   <= status_next;
    end
  end

  assign m_tdata = {6'd0, out_status, out_tfine, out_pressure};

  // --------------------------------------------------------------------------
  // checks
  `BPC_ASSERT(a_zero_den_pressure, m_tvalid && out_status == ST_ZERO_DEN |-> out_pressure == 32'd0)
  `BPC_ASSERT(a_clamp_limits, m_tvalid && out_status == ST_CLAMPED |-> (out_pressure == 32'd0 || out_pressure == 32'hFFFF_FFFF))
  `BPC_ASSERT(a_stall_only_when_full, !s_tready |-> m_tvalid)
  `BPC_ASSERT_ALWAYS(a_empty_after_reset, rst |=> !m_tvalid)

endmodule

// File: sim/baro_pressure_compensation_tb.sv
// ----------------------------------------------------------------------------
// baro_pressure_compensation_tb
// Self-checking bench for the pressure compensation pipeline. Raw
// temperature/pressure items go in over the input stream. Results are checked
// against a 64-bit integer model of t_fine and the compensated pressure. The
// calibration registers are changed between phases, and stream stalls are
// random on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module baro_pressure_compensation_tb;
  import bpc_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct {
    logic [31:0] pressure;
    logic [31:0] tfine;
    logic [1:0]  status;
  } comp_result_t;

  // --------------------------------------------------------------------------
  // scoreboard: calibration copy, pressure predictor, pending results
  // --------------------------------------------------------------------------
  class comp_scoreboard;
    logic [47:0]  temp_cal;
    logic [63:0]  press_a, press_b;
    logic [15:0]  press_c;
    comp_result_t pending[$];
    int           errors;
    int           checked;
    int           n_zero_den;
    int           n_clamped;

    function new();
      temp_cal = '0; press_a = '0; press_b = '0; press_c = '0;
      errors = 0; checked = 0; n_zero_den = 0; n_clamped = 0;
    endfunction

    function void set_reg(bpc_reg_t idx, logic [63:0] val);
      case (idx)
        REG_TEMP_CALIB:    temp_cal = val[47:0];
        REG_PRESS_CALIB_A: press_a  = val;
        REG_PRESS_CALIB_B: press_b  = val;
        REG_PRESS_CALIB_C: press_c  = val[15:0];
        default: ;
      endcase
    endfunction

    function longint sx16(logic [15:0] v);
      return longint'(shortint'(v));
    endfunction

    // compensate one reading; all pressure math wraps at 64 bits
    function comp_result_t compensate(logic [19:0] adc_t, logic [19:0] adc_p);
      comp_result_t r;
      longint t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
      longint da, ta, db, tb, tf, x1, x2, y1, num, q, ps, c9, c8, fin;
      t1 = longint'({48'b0, temp_cal[15:0]});
      t2 = sx16(temp_cal[31:16]);
      t3 = sx16(temp_cal[47:32]);
      p1 = longint'({48'b0, press_a[15:0]});
      p2 = sx16(press_a[31:16]);
      p3 = sx16(press_a[47:32]);
      p4 = sx16(press_a[63:48]);
      p5 = sx16(press_b[15:0]);
      p6 = sx16(press_b[31:16]);
      p7 = sx16(press_b[47:32]);
      p8 = sx16(press_b[63:48]);
      p9 = sx16(press_c);
      // fine temperature
      da = longint'({44'b0, adc_t} >> 3) - (t1 << 1);
      ta = (da * t2) >>> 11;
      db = longint'({44'b0, adc_t} >> 4) - t1;
      tb = (((db * db) >>> 12) * t3) >>> 14;
      tf = ta + tb;
      // pressure
      x1 = tf - 64'sd128000;
      x2 = x1 * x1 * p6 + ((x1 * p5) << 17) + (p4 << 35);
      y1 = ((x1 * x1 * p3) >>> 8) + ((x1 * p2) << 12);
      y1 = (((64'sd1 <<< 47) + y1) * p1) >>> 33;
      r.tfine = tf[31:0];
      if (y1 == 0) begin
        r.pressure = '0;
        r.status   = ST_ZERO_DEN;
      end else begin
        num = (((64'sd1048576 - longint'({44'b0, adc_p})) << 31) - x2) * 64'sd3125;
        // divide by -1 wraps for the most negative numerator
        q   = (y1 == -64'sd1) ? -num : num / y1;
        ps  = q >>> 13;
        c9  = (p9 * ps * ps) >>> 25;
        c8  = (p8 * q) >>> 19;
        fin = ((q + c9 + c8) >>> 8) + (p7 << 4);
        if (fin < 0) begin
          r.pressure = '0;
          r.status   = ST_CLAMPED;
        end else if (fin > 64'sh0000_0000_FFFF_FFFF) begin
          r.pressure = 32'hFFFF_FFFF;
          r.status   = ST_CLAMPED;
        end else begin
          r.pressure = fin[31:0];
          r.status   = ST_OK;
        end
      end
      return r;
    endfunction

    function void note_input(logic [39:0] data);
      comp_result_t r;
      r = compensate(data[19:0], data[39:20]);
      if (r.status == ST_ZERO_DEN) n_zero_den++;
      if (r.status == ST_CLAMPED)  n_clamped++;
      pending.push_back(r);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      $display("[%0t] mismatch %s: got 0x%0h expected 0x%0h", $time, what, got, want);
    endtask

    task check_result(logic [71:0] data);
      comp_result_t e;
      if (pending.size() == 0) begin
        report("unexpected item", data[63:0], 64'h0);
        return;
      end
      e = pending.pop_front();
      checked++;
      if (data[31:0]  !== e.pressure) report("pressure_q24_8", data[31:0], e.pressure);
      if (data[63:32] !== e.tfine)    report("fine_temperature", data[63:32], e.tfine);
      if (data[65:64] !== e.status)   report("status", data[65:64], e.status);
    endtask
  endclass

  logic        clk, rst;
  logic        s_tvalid, s_tready;
  logic [39:0] s_tdata;
  logic        m_tvalid, m_tready;
  logic [71:0] m_tdata;
  logic        psel, penable, pwrite, pready;
  logic [4:0]  paddr;
  logic [63:0] pwdata, prdata;

  comp_scoreboard sb;
  int send_idle, recv_idle;
  int quiet_cycles;

  baro_pressure_compensation u_top (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver stalls
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle);
  end

  // monitor both streams and the watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_input(s_tdata);
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no progress, %0d results still pending", sb.pending.size());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task send_item(logic [19:0] adc_t, logic [19:0] adc_p);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {adc_p, adc_t};
    do @(posedge clk); while (!s_tready);
  endtask

  // setup and access cycle; the caller releases the bus
  task write_reg(bpc_reg_t idx, logic [63:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 5'(idx) << 3;
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task write_calib(logic [47:0] tc, logic [63:0] pa, logic [63:0] pb, logic [15:0] pc);
    write_reg(REG_TEMP_CALIB, {16'h0, tc});
    write_reg(REG_PRESS_CALIB_A, pa);
    write_reg(REG_PRESS_CALIB_B, pb);
    write_reg(REG_PRESS_CALIB_C, {48'h0, pc});
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // typical factory words, each nudged a little
  task write_typical_calib(int jitter);
    logic [15:0] w[12];
    int base[12];
    base = '{27504, 26435, -1000, 36477, -10685, 3024, 2855, 140, -7, 15500,
             -14600, 6000};
    foreach (w[i]) w[i] = 16'(base[i] + $signed($urandom_range(2 * jitter)) - jitter);
    write_calib({w[2], w[1], w[0]}, {w[6], w[5], w[4], w[3]},
                {w[10], w[9], w[8], w[7]}, w[11]);
  endtask

  task drain;
    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  initial begin
    logic [19:0] rt, rp;
    int mode;
    sb = new();
    rst = 1'b1;
    s_tvalid = 1'b0; s_tdata = '0; m_tready = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    send_idle = 0; recv_idle = 0; quiet_cycles = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // cleared calibration: denominator is zero
    send_item(20'h0, 20'h0);
    send_item(20'hFFFFF, 20'hFFFFF);
    drain();

    // typical calibration, field extremes and a realistic reading
    write_typical_calib(0);
    send_item(20'd519888, 20'd415148);
    send_item(20'h0, 20'h0);
    send_item(20'hFFFFF, 20'hFFFFF);
    send_item(20'h0, 20'hFFFFF);
    send_item(20'hFFFFF, 20'h0);
    send_item(20'h80000, 20'h80000);
    send_item(20'h7FFFF, 20'h55555);
    drain();

    // zero P1 forces a zero denominator with a nonzero t_fine
    write_calib({16'hFC18, 16'd26435, 16'd27504}, 64'h0B27_0BD0_D643_0000,
                64'hC6F8_3C8C_FFF9_008C, 16'd6000);
    send_item(20'd519888, 20'd415148);
    send_item(20'hFFFFF, 20'h0);
    drain();

    // every calibration bit set, then the signed extremes
    write_calib('1, '1, '1, '1);
    send_item(20'd519888, 20'd415148);
    send_item(20'hFFFFF, 20'hFFFFF);
    send_item(20'h0, 20'h0);
    drain();
    write_calib({16'h7FFF, 16'h8000, 16'hFFFF}, {16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF},
                {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF}, 16'h8000);
    send_item(20'h0, 20'h0);
    send_item(20'hFFFFF, 20'hFFFFF);
    send_item(20'd519888, 20'h0);
    drain();

    // random phases: calibration changes, idle pattern rotates every three
    for (int ph = 0; ph < 9; ph++) begin
      case (ph / 3)
        0: begin send_idle = 19; recv_idle = 67; end
        1: begin send_idle = 67; recv_idle = 19; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      mode = $urandom_range(3);
      if (mode == 0)
        write_calib(48'({$urandom, $urandom}), {$urandom, $urandom}, {$urandom, $urandom},
                    16'($urandom));
      else
        write_typical_calib(mode == 1 ? 4000 : 200);
      for (int n = 0; n < 100; n++) begin
        if ($urandom_range(1)) begin
          rt = 20'($urandom_range(450000, 600000));
          rp = 20'($urandom_range(250000, 650000));
        end else begin
          rt = 20'($urandom);
          rp = 20'($urandom);
        end
        send_item(rt, rp);
      end
      drain();
    end

    $display("checked %0d results over 14 calibration settings and three stall patterns",
             sb.checked);
    $display("zero-denominator results: %0d, clamped results: %0d",
             sb.n_zero_den, sb.n_clamped);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
